>>> design/assert_macros.svh
// assertion macros shared by the odometry block
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ddo_pkg.sv
// shared types, constants and tables of the odometry block
// no dependencies
package ddo_pkg;

  localparam int IN_W  = 152;
  localparam int OUT_W = 144;
  localparam int CFG_W = 18;

  // register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_INV    = 1'b1;

  localparam logic [15:0] RADIUS_RST = 16'd11469;
  localparam logic [17:0] INV_RST    = 18'd81920;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic signed [33:0] ANG_PI      = 34'sd1686629713;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd843314857;
  localparam logic signed [37:0] CORDIC_GAIN = 38'sd652032875;
  localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [18:0] HEAD_LIMIT  = 19'sd25736;

  // velocity scaling and divider
  localparam logic signed [35:0] VEL_SCALE = 36'sd1000000;
  localparam int DIV_BITS = 56;

  // datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_MUL_L    = 5'd2;
  localparam op_t OP_MUL_R    = 5'd3;
  localparam op_t OP_FWD      = 5'd4;
  localparam op_t OP_MUL_T    = 5'd5;
  localparam op_t OP_Q0       = 5'd6;
  localparam op_t OP_Q1       = 5'd7;
  localparam op_t OP_Q2       = 5'd8;
  localparam op_t OP_Q3       = 5'd9;
  localparam op_t OP_VEC_GO   = 5'd10;
  localparam op_t OP_VEC_END  = 5'd11;
  localparam op_t OP_ROT_GO   = 5'd12;
  localparam op_t OP_ROT_END  = 5'd13;
  localparam op_t OP_MX       = 5'd14;
  localparam op_t OP_MY       = 5'd15;
  localparam op_t OP_ACC      = 5'd16;
  localparam op_t OP_MLIN     = 5'd17;
  localparam op_t OP_DLIN_GO  = 5'd18;
  localparam op_t OP_DLIN_END = 5'd19;
  localparam op_t OP_MROT     = 5'd20;
  localparam op_t OP_DROT_GO  = 5'd21;
  localparam op_t OP_DROT_END = 5'd22;
  localparam op_t OP_OUT      = 5'd23;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic cordic_busy;
    logic div_busy;
    logic time_zero;
  } sts_t;

  // arctangent of 2^-i, Q3.29
  function automatic logic signed [33:0] atan_q29(input logic [4:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // clamp a wide sum to 32 bits
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -35'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // apply sign to a quotient magnitude and clamp to 32 bits
  function automatic logic [31:0] vel_sat(input logic neg, input logic [55:0] q);
    logic [31:0] r;
    if (!neg) r = (q > 56'd2147483647) ? 32'h7fff_ffff : q[31:0];
    else r = (q > 56'd2147483648) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    return r;
  endfunction

endpackage

>>> design/ddo_cordic.sv
// shared cordic unit: vectoring for yaw, rotation for cos and sin
// depends on ddo_pkg
module ddo_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_vec,
  input  logic               start_rot,
  input  logic signed [37:0] x_i,
  input  logic signed [37:0] y_i,
  input  logic signed [33:0] ang_i,
  output logic               busy_o,
  output logic signed [33:0] ang_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import ddo_pkg::*;

  logic               busy_r, busy_nxt;
  logic               rot_r, rot_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [37:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic signed [37:0] sh_x, sh_y, xo, yo;
  logic signed [33:0] at;
  logic               up;

  assign sh_x = x_r >>> cnt_r;
  assign sh_y = y_r >>> cnt_r;
  assign at   = atan_q29(cnt_r);
  assign up   = rot_r ? (z_r >= 0) : (y_r >= 0);

  // start, fold and iterate
  always_comb begin
    busy_nxt = busy_r;
    rot_nxt  = rot_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start_vec) begin
      rot_nxt = 1'b0;
      neg_nxt = 1'b0;
      cnt_nxt = '0;
      if (x_i == 0 && y_i == 0) begin
        x_nxt = '0;
        y_nxt = '0;
        z_nxt = '0;
      end else if (x_i < 0) begin
        busy_nxt = 1'b1;
        x_nxt = -x_i;
        y_nxt = -y_i;
        z_nxt = (y_i >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        busy_nxt = 1'b1;
        x_nxt = x_i;
        y_nxt = y_i;
        z_nxt = '0;
      end
    end else if (start_rot) begin
      busy_nxt = 1'b1;
      rot_nxt  = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      if (ang_i > ANG_HALF_PI) begin
        z_nxt = ang_i - ANG_PI;
        neg_nxt = 1'b1;
      end else if (ang_i < -ANG_HALF_PI) begin
        z_nxt = ang_i + ANG_PI;
        neg_nxt = 1'b1;
      end else begin
        z_nxt = ang_i;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (up ^ rot_r) begin
        // vectoring with y >= 0, or rotation with z < 0
        x_nxt = x_r + sh_y;
        y_nxt = y_r - sh_x;
      end else begin
        x_nxt = x_r - sh_y;
        y_nxt = y_r + sh_x;
      end
      if (up ^ rot_r) z_nxt = z_r + at;
      else z_nxt = z_r - at;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(CORDIC_N - 1)) busy_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rot_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rot_r  <= rot_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign xo     = neg_r ? -x_r : x_r;
  assign yo     = neg_r ? -y_r : y_r;
  assign busy_o = busy_r;
  assign ang_o  = z_r;
  assign cos_o  = xo[31:0];
  assign sin_o  = yo[31:0];

endmodule

>>> design/ddo_div.sv
// restoring divider, one quotient bit per cycle
// depends on ddo_pkg
module ddo_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddo_pkg::DIV_BITS-1:0] dividend,
  input  logic [23:0]                  divisor,
  output logic                         busy_o,
  output logic [ddo_pkg::DIV_BITS-1:0] quot_o
);
  import ddo_pkg::*;

  logic                busy_r, busy_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0] dvd_r, dvd_nxt;
  logic [23:0]         rem_r, rem_nxt;
  logic [23:0]         dsr_r, dsr_nxt;
  logic [24:0]         rem_sh, rem_sub;
  logic                ge;

  assign rem_sh  = {rem_r, dvd_r[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  // shift in one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[23:0] : rem_sh[23:0];
      dvd_nxt = {dvd_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_BITS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy_o = busy_r;
  assign quot_o = dvd_r;

endmodule

>>> design/ddo_dp.sv
// datapath: config registers, odometry state, shared multiplier,
// cordic and divider; depends on ddo_pkg, ddo_cordic, ddo_div
module ddo_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [ddo_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [ddo_pkg::IN_W-1:0]  in_tdata,
  input  ddo_pkg::cmd_t             cmd_i,
  output ddo_pkg::sts_t             sts_o,
  output logic [ddo_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tuser
);
  import ddo_pkg::*;

  // config and model state
  logic [15:0] radius_r;
  logic [17:0] inv_r;
  logic        primed_r;
  logic [31:0] last_l_r, last_r_r;
  logic [31:0] accx_r, accy_r;

  // latched item and intermediates
  logic [31:0]        left_r, right_r;
  logic [15:0]        qw_r, qx_r, qy_r, qz_r;
  logic [23:0]        elapsed_r;
  logic [31:0]        dl_r, dr_r, fwd_r;
  logic [32:0]        diff_r;
  logic [34:0]        turn_r;
  logic [32:0]        qacc_r;
  logic signed [33:0] num_r, den_r, ang_r;
  logic signed [31:0] c_r, s_r;
  logic [33:0]        tx_r, ty_r;
  logic [55:0]        vprod_r;
  logic [31:0]        lin_r, rot_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_user_r;

  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod;
  logic [31:0]        dlt_l, dlt_r;
  logic [32:0]        qsum, fsum;
  logic signed [34:0] sumx, sumy, hsum;
  logic signed [18:0] hq;
  logic [15:0]        head;
  logic [55:0]        vmag;
  logic               cordic_busy, div_busy;
  logic signed [33:0] cordic_ang;
  logic signed [31:0] cordic_cos, cordic_sin;
  logic [55:0]        quot;

  assign dlt_l = left_r - last_l_r;
  assign dlt_r = right_r - last_r_r;

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_L: begin
        mul_a = {{4{dlt_l[31]}}, dlt_l};
        mul_b = {20'd0, radius_r};
      end
      OP_MUL_R: begin
        mul_a = {{4{dlt_r[31]}}, dlt_r};
        mul_b = {20'd0, radius_r};
      end
      OP_MUL_T: begin
        mul_a = {{3{diff_r[32]}}, diff_r};
        mul_b = {18'd0, inv_r};
      end
      OP_Q0: begin
        mul_a = {{20{qw_r[15]}}, qw_r};
        mul_b = {{20{qz_r[15]}}, qz_r};
      end
      OP_Q1: begin
        mul_a = {{20{qx_r[15]}}, qx_r};
        mul_b = {{20{qy_r[15]}}, qy_r};
      end
      OP_Q2: begin
        mul_a = {{20{qy_r[15]}}, qy_r};
        mul_b = {{20{qy_r[15]}}, qy_r};
      end
      OP_Q3: begin
        mul_a = {{20{qz_r[15]}}, qz_r};
        mul_b = {{20{qz_r[15]}}, qz_r};
      end
      OP_MX: begin
        mul_a = {{4{fwd_r[31]}}, fwd_r};
        mul_b = {{4{c_r[31]}}, c_r};
      end
      OP_MY: begin
        mul_a = {{4{fwd_r[31]}}, fwd_r};
        mul_b = {{4{s_r[31]}}, s_r};
      end
      OP_MLIN: begin
        mul_a = {{4{fwd_r[31]}}, fwd_r};
        mul_b = VEL_SCALE;
      end
      OP_MROT: begin
        mul_a = {turn_r[34], turn_r};
        mul_b = VEL_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // small adders around the multiplier
  assign qsum = qacc_r + prod[32:0];
  assign fsum = {dl_r[31], dl_r} + {dr_r[31], dr_r};
  assign sumx = {{3{accx_r[31]}}, accx_r} + {tx_r[33], tx_r};
  assign sumy = {{3{accy_r[31]}}, accy_r} + {ty_r[33], ty_r};
  assign vmag = vprod_r[55] ? (56'd0 - vprod_r) : vprod_r;

  // heading rounded to Q3.13 and clamped
  assign hsum = {ang_r[33], ang_r} + 35'sd32768;
  assign hq   = hsum[34:16];
  always_comb begin
    if (hq > HEAD_LIMIT) head = HEAD_LIMIT[15:0];
    else if (hq < -HEAD_LIMIT) head = 16'(-HEAD_LIMIT);
    else head = hq[15:0];
  end

  ddo_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_vec(cmd_i.op == OP_VEC_GO),
    .start_rot(cmd_i.op == OP_ROT_GO),
    .x_i      ({{4{den_r[33]}}, den_r}),
    .y_i      ({{4{num_r[33]}}, num_r}),
    .ang_i    (ang_r),
    .busy_o   (cordic_busy),
    .ang_o    (cordic_ang),
    .cos_o    (cordic_cos),
    .sin_o    (cordic_sin)
  );

  ddo_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd_i.op == OP_DLIN_GO || cmd_i.op == OP_DROT_GO),
    .dividend(vmag),
    .divisor (elapsed_r),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // config and odometry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      inv_r    <= INV_RST;
      primed_r <= 1'b0;
      last_l_r <= '0;
      last_r_r <= '0;
      accx_r   <= '0;
      accy_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RADIUS: radius_r <= cfg_wdata[15:0];
          REG_INV:    inv_r    <= cfg_wdata[17:0];
        endcase
      end
      if (cmd_i.op == OP_LOAD && !primed_r) begin
        primed_r <= 1'b1;
        last_l_r <= in_tdata[31:0];
        last_r_r <= in_tdata[63:32];
      end
      if (cmd_i.op == OP_FWD) begin
        last_l_r <= left_r;
        last_r_r <= right_r;
      end
      if (cmd_i.op == OP_ACC) begin
        accx_r <= sat32(sumx);
        accy_r <= sat32(sumy);
      end
    end
  end

  // working registers, one step per command
  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        left_r    <= in_tdata[31:0];
        right_r   <= in_tdata[63:32];
        qw_r      <= in_tdata[79:64];
        qx_r      <= in_tdata[95:80];
        qy_r      <= in_tdata[111:96];
        qz_r      <= in_tdata[127:112];
        elapsed_r <= in_tdata[151:128];
      end
      OP_MUL_L: dl_r <= prod[47:16];
      OP_MUL_R: dr_r <= prod[47:16];
      OP_FWD: begin
        fwd_r  <= fsum[32:1];
        diff_r <= {dr_r[31], dr_r} - {dl_r[31], dl_r};
        lin_r  <= '0;
        rot_r  <= '0;
      end
      OP_MUL_T:    turn_r <= prod[50:16];
      OP_Q0:       qacc_r <= prod[32:0];
      OP_Q1:       num_r  <= {qsum, 1'b0};
      OP_Q2:       qacc_r <= prod[32:0];
      OP_Q3:       den_r  <= ONE_Q28 - {qsum, 1'b0};
      OP_VEC_END:  ang_r  <= cordic_ang;
      OP_ROT_END: begin
        c_r <= cordic_cos;
        s_r <= cordic_sin;
      end
      OP_MX:       tx_r    <= prod[63:30];
      OP_MY:       ty_r    <= prod[63:30];
      OP_MLIN:     vprod_r <= prod[55:0];
      OP_DLIN_END: lin_r   <= vel_sat(vprod_r[55], quot);
      OP_MROT:     vprod_r <= prod[55:0];
      OP_DROT_END: rot_r   <= vel_sat(vprod_r[55], quot);
      OP_OUT: begin
        out_data_r <= {rot_r, lin_r, head, accy_r, accx_r};
        out_user_r <= (elapsed_r == 24'd0);
      end
      default: ;
    endcase
  end

  assign sts_o.primed      = primed_r;
  assign sts_o.cordic_busy = cordic_busy;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.time_zero   = (elapsed_r == 24'd0);
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

>>> design/ddo_ctrl.sv
// sequencer: walks one item through the datapath, owns the handshakes
// depends on ddo_pkg
module ddo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  ddo_pkg::sts_t sts_i,
  output ddo_pkg::cmd_t cmd_o
);
  import ddo_pkg::*;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_MUL_L     = 5'd1;
  localparam logic [4:0] ST_MUL_R     = 5'd2;
  localparam logic [4:0] ST_FWD       = 5'd3;
  localparam logic [4:0] ST_MUL_T     = 5'd4;
  localparam logic [4:0] ST_Q0        = 5'd5;
  localparam logic [4:0] ST_Q1        = 5'd6;
  localparam logic [4:0] ST_Q2        = 5'd7;
  localparam logic [4:0] ST_Q3        = 5'd8;
  localparam logic [4:0] ST_VEC_GO    = 5'd9;
  localparam logic [4:0] ST_VEC_WAIT  = 5'd10;
  localparam logic [4:0] ST_VEC_END   = 5'd11;
  localparam logic [4:0] ST_ROT_GO    = 5'd12;
  localparam logic [4:0] ST_ROT_WAIT  = 5'd13;
  localparam logic [4:0] ST_ROT_END   = 5'd14;
  localparam logic [4:0] ST_MX        = 5'd15;
  localparam logic [4:0] ST_MY        = 5'd16;
  localparam logic [4:0] ST_ACC       = 5'd17;
  localparam logic [4:0] ST_MLIN      = 5'd18;
  localparam logic [4:0] ST_DLIN_GO   = 5'd19;
  localparam logic [4:0] ST_DLIN_WAIT = 5'd20;
  localparam logic [4:0] ST_DLIN_END  = 5'd21;
  localparam logic [4:0] ST_MROT      = 5'd22;
  localparam logic [4:0] ST_DROT_GO   = 5'd23;
  localparam logic [4:0] ST_DROT_WAIT = 5'd24;
  localparam logic [4:0] ST_DROT_END  = 5'd25;
  localparam logic [4:0] ST_OUT       = 5'd26;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd_o.op  = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.op = OP_LOAD;
          if (sts_i.primed) state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: begin cmd_o.op = OP_MUL_L; state_nxt = ST_MUL_R; end
      ST_MUL_R: begin cmd_o.op = OP_MUL_R; state_nxt = ST_FWD; end
      ST_FWD:   begin cmd_o.op = OP_FWD;   state_nxt = ST_MUL_T; end
      ST_MUL_T: begin cmd_o.op = OP_MUL_T; state_nxt = ST_Q0; end
      ST_Q0:    begin cmd_o.op = OP_Q0;    state_nxt = ST_Q1; end
      ST_Q1:    begin cmd_o.op = OP_Q1;    state_nxt = ST_Q2; end
      ST_Q2:    begin cmd_o.op = OP_Q2;    state_nxt = ST_Q3; end
      ST_Q3:    begin cmd_o.op = OP_Q3;    state_nxt = ST_VEC_GO; end
      ST_VEC_GO: begin cmd_o.op = OP_VEC_GO; state_nxt = ST_VEC_WAIT; end
      ST_VEC_WAIT: begin
        if (!sts_i.cordic_busy) state_nxt = ST_VEC_END;
      end
      ST_VEC_END: begin cmd_o.op = OP_VEC_END; state_nxt = ST_ROT_GO; end
      ST_ROT_GO:  begin cmd_o.op = OP_ROT_GO;  state_nxt = ST_ROT_WAIT; end
      ST_ROT_WAIT: begin
        if (!sts_i.cordic_busy) state_nxt = ST_ROT_END;
      end
      ST_ROT_END: begin cmd_o.op = OP_ROT_END; state_nxt = ST_MX; end
      ST_MX:      begin cmd_o.op = OP_MX;      state_nxt = ST_MY; end
      ST_MY:      begin cmd_o.op = OP_MY;      state_nxt = ST_ACC; end
      ST_ACC: begin
        cmd_o.op  = OP_ACC;
        state_nxt = sts_i.time_zero ? ST_OUT : ST_MLIN;
      end
      ST_MLIN:    begin cmd_o.op = OP_MLIN;    state_nxt = ST_DLIN_GO; end
      ST_DLIN_GO: begin cmd_o.op = OP_DLIN_GO; state_nxt = ST_DLIN_WAIT; end
      ST_DLIN_WAIT: begin
        if (!sts_i.div_busy) state_nxt = ST_DLIN_END;
      end
      ST_DLIN_END: begin cmd_o.op = OP_DLIN_END; state_nxt = ST_MROT; end
      ST_MROT:     begin cmd_o.op = OP_MROT;     state_nxt = ST_DROT_GO; end
      ST_DROT_GO:  begin cmd_o.op = OP_DROT_GO;  state_nxt = ST_DROT_WAIT; end
      ST_DROT_WAIT: begin
        if (!sts_i.div_busy) state_nxt = ST_DROT_END;
      end
      ST_DROT_END: begin cmd_o.op = OP_DROT_END; state_nxt = ST_OUT; end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op  = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    priority if (state_r == ST_OUT && out_free) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> design/diff_drive_imu_odometry.sv
// channel  | dir | data                                   | side
// in_      | in  | tdata: angles, quaternion, elapsed_us  | tvalid/tready
// out_     | out | tdata: pose, heading, velocities       | tuser: time_error
// cfg_     | in  | cfg_addr selects register, cfg_wdata   | cfg_we, no wait
// the first item after reset only primes the wheel angles and yields no result
// later items run through the two cordic passes and the two divisions;
// the divisions are skipped when elapsed_us is 0
// one item in flight; a new item is taken while the result waits in the output register
// reset is synchronous, active low
`include "assert_macros.svh"
module diff_drive_imu_odometry (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [ddo_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // left_angle, right_angle, quat_w, quat_x, quat_y, quat_z, elapsed_us
  input  logic [ddo_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // pos_x, pos_y, heading, linear_velocity, angular_velocity
  output logic [ddo_pkg::OUT_W-1:0] out_tdata,
  // time_error
  output logic                      out_tuser
);
  import ddo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ddo_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tdata (in_tdata),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // checks
  `ASSERT_ALWAYS(a_ready_units_idle, !(in_tready && (sts.cordic_busy || sts.div_busy)), "ready while a unit is busy")
  `ASSERT_ALWAYS(a_one_unit_busy, !(sts.cordic_busy && sts.div_busy), "cordic and divider busy together")
  `ASSERT_NEXT(a_primed_item_runs, in_tvalid && in_tready && sts.primed, !in_tready, "primed item did not start")

endmodule
